[hw/rtl/mh3_pkg.sv]
// Shared types and constants for the MurmurHash3 x86_32 hash unit.
// Depends on nothing; imported by the top level, front end, back end and checker.
package mh3_pkg;

    localparam logic [31:0] MIX_C1    = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2    = 32'h1b873593;
    localparam logic [31:0] ROUND_ADD = 32'he6546b64;
    localparam logic [31:0] FIN_M1    = 32'h85ebca6b;
    localparam logic [31:0] FIN_M2    = 32'hc2b2ae35;

    localparam int DEF_QUEUE_DEPTH  = 4;
    localparam int DEF_RESULT_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_TAIL,
        KIND_FULL
    } t_kind;

    typedef struct packed {
        logic [31:0] k;
        t_kind       kind;
        logic [2:0]  len_add;
        logic        last;
    } t_work;

endpackage

[hw/rtl/murmur3_32_hash_unit.sv]
// Top level of the MurmurHash3 x86_32 hash unit: front end, work queue,
// back end and result queue. Depends on mh3_pkg, mh3_fifo, mh3_front, mh3_back.
//
//  Channel   Direction  Handshake          Word
//  input     in         push / full        i_key_word, i_byte_count, i_last_word
//  result    out        empty / pop        o_hash_value
//  seed      in         i_seed_we          i_seed_data
//
// One key word is taken per cycle while the work queue has room; the back end
// folds one word per cycle into the running hash through its rotate and add,
// while the work queue holds words and a last word finds result queue room.
// Words pass scramble stages s1 and s2 into the work queue; hashes pass
// registers f, a1 and a2 into the result queue. Reset clears the seed, hash
// state and both queues; full rises when queued plus scrambling words reach
// the queue depth, and a stalled result queue holds back only last words.
module murmur3_32_hash_unit
    import mh3_pkg::*;
#(
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
    parameter int RESULT_DEPTH = DEF_RESULT_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_key_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last_word,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_hash_value,
    input  logic        i_seed_we,
    input  logic [31:0] i_seed_data
);

    localparam int WorkW = $bits(t_work);
    localparam int QCW   = $clog2(QUEUE_DEPTH + 1);
    localparam int RCW   = $clog2(RESULT_DEPTH + 1);

    logic             q_push;
    t_work            q_wdata;
    logic [WorkW-1:0] q_rdata_raw;
    t_work            q_rdata;
    logic             q_pop;
    logic             q_empty;
    logic [QCW-1:0]   q_count;
    logic             res_push;
    logic [31:0]      res_data;
    logic [RCW-1:0]   res_count;

    assign q_rdata = t_work'(q_rdata_raw);

    mh3_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_key_word   (i_key_word),
        .i_byte_count (i_byte_count),
        .i_last_word  (i_last_word),
        .i_q_count    (q_count),
        .o_q_push     (q_push),
        .o_q_data     (q_wdata)
    );

    mh3_fifo #(
        .WIDTH (WorkW),
        .DEPTH (QUEUE_DEPTH)
    ) u_work_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata_raw),
        .o_count (q_count)
    );

    mh3_back #(
        .RDEPTH (RESULT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_data    (q_rdata),
        .o_q_pop     (q_pop),
        .i_seed_we   (i_seed_we),
        .i_seed_data (i_seed_data),
        .i_res_count (res_count),
        .o_res_push  (res_push),
        .o_res_data  (res_data)
    );

    mh3_fifo #(
        .WIDTH (32),
        .DEPTH (RESULT_DEPTH)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_data),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_hash_value),
        .o_count (res_count)
    );

endmodule

[hw/rtl/mh3_fifo.sv]
// Small synchronous queue of words with a fill count.
// Depends on nothing; used between the front and back and for results.
module mh3_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic [WIDTH-1:0]           o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_pop;

    assign do_pop  = i_pop && (r_count != '0);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !do_pop) |-> (r_count < CW'(DEPTH)))
        else $error("queue written while full");

endmodule

[hw/rtl/mh3_front.sv]
// Front end: accepts key words, classifies them and scrambles the key word.
// Depends on mh3_pkg; feeds the work queue read by mh3_back.
module mh3_front
    import mh3_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    output logic                       o_full,
    input  logic [31:0]                i_key_word,
    input  logic [2:0]                 i_byte_count,
    input  logic                       i_last_word,
    input  logic [$clog2(DEPTH+1)-1:0] i_q_count,
    output logic                       o_q_push,
    output t_work                      o_q_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 2;

    logic          accept;
    logic [2:0]    eff_count;
    logic [31:0]   tail_mask;
    t_work         cls;
    logic [SW-1:0] used;
    logic [31:0]   rot_prod;
    t_work         s2_next;

    logic          r_s1_valid;
    logic [31:0]   r_s1_prod;
    t_work         r_s1_info;
    logic          r_s2_valid;
    t_work         r_s2_work;

    // Queue entries plus words still in the scramble stages must leave a free slot.
    assign used   = SW'(i_q_count) + SW'(r_s1_valid) + SW'(r_s2_valid);
    assign o_full = (used >= SW'(DEPTH));
    assign accept = i_push && !o_full;

    always_comb begin
        eff_count = (i_byte_count > 3'd4) ? 3'd4 : i_byte_count;
        unique case (eff_count)
            3'd1:    tail_mask = 32'h0000_00ff;
            3'd2:    tail_mask = 32'h0000_ffff;
            3'd3:    tail_mask = 32'h00ff_ffff;
            default: tail_mask = 32'hffff_ffff;
        endcase
        cls.last = i_last_word;
        if (!i_last_word) begin
            cls.kind    = KIND_FULL;
            cls.len_add = 3'd4;
            cls.k       = i_key_word;
        end else begin
            cls.len_add = eff_count;
            cls.k       = i_key_word & tail_mask;
            if (eff_count == 3'd4) begin
                cls.kind = KIND_FULL;
            end else if (eff_count != 3'd0) begin
                cls.kind = KIND_TAIL;
            end else begin
                cls.kind = KIND_NONE;
            end
        end
    end

    assign rot_prod = {r_s1_prod[16:0], r_s1_prod[31:17]};

    always_comb begin
        s2_next   = r_s1_info;
        s2_next.k = rot_prod * MIX_C2;
    end

    always_ff @(posedge i_clk) begin
        r_s1_prod <= cls.k * MIX_C1;
        r_s1_info <= cls;
        r_s2_work <= s2_next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
        end
    end

    assign o_q_push = r_s2_valid;
    assign o_q_data = r_s2_work;

    a_room_for_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> (i_q_count < CW'(DEPTH)))
        else $error("scrambled word arrives at a full queue");

    a_accept_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted word lost in the first stage");

endmodule

[hw/rtl/mh3_back.sv]
// Back end: folds scrambled words into the running hash and finishes each key.
// Depends on mh3_pkg; reads the work queue and writes the result queue.
module mh3_back
    import mh3_pkg::*;
#(
    parameter int RDEPTH = DEF_RESULT_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  t_work                       i_q_data,
    output logic                        o_q_pop,
    input  logic                        i_seed_we,
    input  logic [31:0]                 i_seed_data,
    input  logic [$clog2(RDEPTH+1)-1:0] i_res_count,
    output logic                        o_res_push,
    output logic [31:0]                 o_res_data
);

    localparam int CW = $clog2(RDEPTH + 1);
    localparam int SW = CW + 2;

    logic [SW-1:0] used;
    logic          room;
    logic [31:0]   h_xor;
    logic [31:0]   h_rot;
    logic [31:0]   h_new;
    logic [31:0]   len_new;
    logic [31:0]   f_mix;
    logic [31:0]   a1_mix;

    logic [31:0]   r_seed;
    logic [31:0]   r_hash;
    logic [31:0]   r_key_len;
    logic          r_f_valid;
    logic [31:0]   r_f_val;
    logic          r_a1_valid;
    logic [31:0]   r_a1_val;
    logic          r_a2_valid;
    logic [31:0]   r_a2_val;

    assign used    = SW'(i_res_count) + SW'(r_f_valid) + SW'(r_a1_valid) + SW'(r_a2_valid);
    assign room    = (used < SW'(RDEPTH));
    assign o_q_pop = !i_q_empty && (!i_q_data.last || room);

    always_comb begin
        h_xor = r_hash ^ i_q_data.k;
        h_rot = {h_xor[18:0], h_xor[31:19]};
        unique case (i_q_data.kind)
            KIND_FULL: h_new = (h_rot << 2) + h_rot + ROUND_ADD;
            KIND_TAIL: h_new = h_xor;
            default:   h_new = r_hash;
        endcase
        len_new = r_key_len + 32'(i_q_data.len_add);
    end

    assign f_mix  = r_f_val ^ (r_f_val >> 16);
    assign a1_mix = r_a1_val ^ (r_a1_val >> 13);

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_f_val <= h_new ^ len_new;
        end
        r_a1_val <= f_mix * FIN_M1;
        r_a2_val <= a1_mix * FIN_M2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed     <= '0;
            r_hash     <= '0;
            r_key_len  <= '0;
            r_f_valid  <= 1'b0;
            r_a1_valid <= 1'b0;
            r_a2_valid <= 1'b0;
        end else begin
            r_f_valid  <= o_q_pop && i_q_data.last;
            r_a1_valid <= r_f_valid;
            r_a2_valid <= r_a1_valid;
            if (o_q_pop) begin
                if (i_q_data.last) begin
                    r_key_len <= '0;
                end else begin
                    r_key_len <= len_new;
                end
            end
            if (i_seed_we) begin
                r_seed <= i_seed_data;
            end
            if (i_seed_we && (r_key_len == '0)) begin
                r_hash <= i_seed_data;
            end else if (o_q_pop) begin
                if (i_q_data.last) begin
                    r_hash <= r_seed;
                end else begin
                    r_hash <= h_new;
                end
            end
        end
    end

    assign o_res_push = r_a2_valid;
    assign o_res_data = r_a2_val ^ (r_a2_val >> 16);

    a_room_for_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a2_valid |-> (i_res_count < CW'(RDEPTH)))
        else $error("finished hash arrives at a full result queue");

    a_new_key_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_q_data.last) |=> (r_key_len == '0))
        else $error("key length not cleared after the last word");

    a_final_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f_valid |-> ##2 r_a2_valid)
        else $error("finalisation stage lost a hash");

endmodule

[tb/hash_checker.sv]
// Checker for the MurmurHash3 x86_32 hash unit: watches the key, result and seed ports,
// predicts every finished hash and compares it with the word popped from the unit.
// Depends on mh3_pkg for the mixing constants.
`timescale 1ns / 100ps

module hash_checker
    import mh3_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [31:0] i_key_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last_word,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [31:0] i_hash_value,
    input  logic        i_seed_we,
    input  logic [31:0] i_seed_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_hashes
);

    logic [31:0] seed_reg;
    logic [31:0] hash_acc;
    logic [31:0] byte_total;
    logic [31:0] hash_queue[$];

    function automatic logic [31:0] rol(input logic [31:0] v, input int unsigned r);
        return (v << r) | (v >> (32 - r));
    endfunction

    function automatic logic [31:0] scramble_word(input logic [31:0] k);
        logic [31:0] t;
        t = k * MIX_C1;
        t = rol(t, 15);
        t = t * MIX_C2;
        return t;
    endfunction

    function automatic logic [31:0] fold_round(input logic [31:0] h, input logic [31:0] w);
        logic [31:0] t;
        t = rol(h ^ scramble_word(w), 13);
        t = t * 32'd5 + ROUND_ADD;
        return t;
    endfunction

    function automatic logic [31:0] finish_hash(input logic [31:0] h);
        logic [31:0] t;
        t = h ^ (h >> 16);
        t = t * FIN_M1;
        t = t ^ (t >> 13);
        t = t * FIN_M2;
        t = t ^ (t >> 16);
        return t;
    endfunction

    task automatic note_error(input string what, input logic [31:0] want,
                              input logic [31:0] got);
        o_errors++;
        if (o_errors <= 10) begin
            $display("tb: %s, expected %08h, got %08h", what, want, got);
        end
    endtask

    task automatic absorb_word(input logic [31:0] w, input logic [2:0] cnt, input logic last);
        logic [2:0]  n;
        logic [31:0] mask;
        if (!last) begin
            hash_acc = fold_round(hash_acc, w);
            byte_total = byte_total + 32'd4;
        end else begin
            n = (cnt > 3'd4) ? 3'd4 : cnt;
            if (n == 3'd4) begin
                hash_acc = fold_round(hash_acc, w);
            end else if (n != 3'd0) begin
                mask = (32'd1 << (8 * n)) - 32'd1;
                hash_acc = hash_acc ^ scramble_word(w & mask);
            end
            byte_total = byte_total + 32'(n);
            hash_queue.push_back(finish_hash(hash_acc ^ byte_total));
            hash_acc = seed_reg;
            byte_total = '0;
        end
    endtask

    always @(posedge i_clk) begin
        logic [31:0] want;
        if (!i_rst_n) begin
            seed_reg = '0;
            hash_acc = '0;
            byte_total = '0;
            hash_queue.delete();
            o_errors = 0;
            o_hashes = 0;
        end else begin
            if (i_pop && !i_empty) begin
                if (hash_queue.size() == 0) begin
                    note_error("hash popped with none outstanding", '0, i_hash_value);
                end else begin
                    want = hash_queue.pop_front();
                    o_hashes++;
                    if (want !== i_hash_value) begin
                        note_error("hash mismatch", want, i_hash_value);
                    end
                end
            end
            if (i_push && !i_full) begin
                absorb_word(i_key_word, i_byte_count, i_last_word);
            end
            if (i_seed_we) begin
                seed_reg = i_seed_data;
                if (byte_total == '0) begin
                    hash_acc = seed_reg;
                end
            end
        end
        o_pending = hash_queue.size();
    end

endmodule

[tb/tb_top.sv]
// Top of the hash unit testbench: drives keys, seeds and result pops with random gaps
// and stalls, and gives the verdict. Depends on murmur3_32_hash_unit and hash_checker.
`timescale 1ns / 100ps

module tb_top;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [31:0] i_key_word;
    logic [2:0]  i_byte_count;
    logic        i_last_word;
    logic        empty;
    logic        pop;
    logic [31:0] o_hash_value;
    logic        i_seed_we;
    logic [31:0] i_seed_data;

    int errors;
    int pending;
    int hashes;
    int words_sent;
    bit send_gaps;
    bit recv_gaps;
    bit hold_req;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    murmur3_32_hash_unit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_key_word   (i_key_word),
        .i_byte_count (i_byte_count),
        .i_last_word  (i_last_word),
        .empty        (empty),
        .pop          (pop),
        .o_hash_value (o_hash_value),
        .i_seed_we    (i_seed_we),
        .i_seed_data  (i_seed_data)
    );

    hash_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_key_word   (i_key_word),
        .i_byte_count (i_byte_count),
        .i_last_word  (i_last_word),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_hash_value (o_hash_value),
        .i_seed_we    (i_seed_we),
        .i_seed_data  (i_seed_data),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_hashes     (hashes)
    );

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                pop <= 1'b0;
            end else if (hold_req) begin
                pop <= 1'b0;
                hold_req = 1'b0;
                repeat (300) @(negedge i_clk);
            end else begin
                pop <= !(recv_gaps && $urandom_range(0, 99) < 18);
            end
        end
    end

    function automatic logic [31:0] pick_word();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            return 32'h0000_0000;
        end else if (sel == 1) begin
            return 32'hffff_ffff;
        end
        return $urandom();
    endfunction

    task automatic send_word(input logic [31:0] w, input logic [2:0] cnt, input logic last);
        while (send_gaps && $urandom_range(0, 99) < 18) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_key_word <= w;
        i_byte_count <= cnt;
        i_last_word <= last;
        do @(posedge i_clk); while (full);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_key(input int unsigned n_words);
        for (int unsigned i = 1; i < n_words; i++) begin
            send_word(pick_word(), 3'($urandom_range(0, 7)), 1'b0);
        end
        send_word(pick_word(), 3'($urandom_range(0, 7)), 1'b1);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        i_seed_we <= 1'b1;
        i_seed_data <= value;
        @(negedge i_clk);
        i_seed_we <= 1'b0;
    endtask

    initial begin
        int unsigned phase_words;
        logic [31:0] phase_seed;
        i_rst_n = 1'b0;
        push = 1'b0;
        i_key_word = '0;
        i_byte_count = '0;
        i_last_word = 1'b0;
        i_seed_we = 1'b0;
        i_seed_data = '0;
        pop = 1'b0;
        words_sent = 0;
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        hold_req = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_word(32'h0000_0000, 3'd0, 1'b1);
        send_word(32'hffff_ffab, 3'd1, 1'b1);
        send_word(32'hdead_1234, 3'd2, 1'b1);
        send_word(32'h89ab_cdef, 3'd3, 1'b1);
        send_word(32'hffff_ffff, 3'd4, 1'b1);
        send_word(32'h1234_5678, 3'd5, 1'b1);
        send_word(32'h8765_4321, 3'd6, 1'b1);
        send_word(32'hffff_ffff, 3'd7, 1'b1);
        send_word(32'h0000_0000, 3'd1, 1'b0);
        send_word(32'hffff_ffff, 3'd0, 1'b0);
        send_word(32'h5555_aaaa, 3'd0, 1'b1);
        wait_drained();
        write_seed(32'hffff_ffff);
        send_word(32'h0102_0304, 3'd4, 1'b0);
        send_word(32'ha5a5_a5a5, 3'd2, 1'b1);
        send_word(32'hcafe_f00d, 3'd4, 1'b0);
        wait_drained();
        write_seed(32'h5eed_0001);
        send_word(32'h0bad_f00d, 3'd3, 1'b1);
        send_word(32'h0000_0011, 3'd1, 1'b1);
        wait_drained();

        hold_req = 1'b1;
        repeat (40) send_word(pick_word(), 3'($urandom_range(0, 7)), 1'b1);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: phase_seed = 32'h0000_0000;
                1: phase_seed = 32'hffff_ffff;
                default: phase_seed = $urandom();
            endcase
            write_seed(phase_seed);
            send_gaps = (phase != 1);
            recv_gaps = (phase != 1);
            phase_words = 0;
            while (phase_words < 150) begin
                int unsigned len;
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 6);
                send_key(len);
                phase_words += len;
            end
            wait_drained();
        end

        $display("tb: %0d key words driven and %0d hashes compared across several seeds,",
                 words_sent, hashes);
        $display("tb: with gaps and stalls on both sides and a long result hold-off.");
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/mh3_pkg.sv
hw/rtl/mh3_fifo.sv
hw/rtl/mh3_front.sv
hw/rtl/mh3_back.sv
hw/rtl/murmur3_32_hash_unit.sv
tb/hash_checker.sv
tb/tb_top.sv
